FILE: sv/swu_pkg.sv
// ----------------------------------------------------------------------------
// swu_pkg: shared types and constants for the single-wire 8E2 UART
// Register indexes, field widths and the per-tick result record.
// ----------------------------------------------------------------------------
`default_nettype none

package swu_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_TX_BIT_CYCLES = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RX_BIT_CYCLES = 8'd1;

    localparam logic [CFG_DATA_W-1:0] BIT_CYCLES_RESET = 16'd16;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int TIMER_W = 16;
    localparam int COUNT_W = 8;

    // Stream data widths (fields packed from bit 0, padded to whole bytes)
    localparam int S_FIELDS_W = 1 + BYTE_W + 1;
    localparam int S_TDATA_W  = 16;
    localparam int M_FIELDS_W = 3 + BYTE_W + 1 + COUNT_W;
    localparam int M_TDATA_W  = 24;

    // One result item
    typedef struct packed {
        logic [COUNT_W-1:0] parity_fault_count;
        logic               parity_bad;
        logic [BYTE_W-1:0]  received_byte;
        logic               byte_ready;
        logic               sender_busy;
        logic               line_pull_low;
    } result_t;

    // One input item
    typedef struct packed {
        logic              line_sample;
        logic [BYTE_W-1:0] send_byte;
        logic              send_request;
    } item_t;

endpackage

`default_nettype wire

FILE: sv/swu_core.sv
// ----------------------------------------------------------------------------
// swu_core: transmitter and receiver state for one line tick
// Computes the next UART state and the result of one tick; commits on step.
// ----------------------------------------------------------------------------
`default_nettype none

module swu_core #(
    parameter int DATA_BITS = 8,
    parameter int STOP_BITS = 2
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              step,
    input  swu_pkg::item_t                   item,
    input  wire  [swu_pkg::TIMER_W-1:0]      tx_period,
    input  wire  [swu_pkg::TIMER_W-1:0]      rx_period,
    output swu_pkg::result_t                 result
);
    import swu_pkg::*;

    localparam int PW = $clog2(DATA_BITS + STOP_BITS + 3);
    localparam logic [PW-1:0] PH_IDLE   = PW'(0);
    localparam logic [PW-1:0] PH_START  = PW'(1);
    localparam logic [PW-1:0] PH_DATA0  = PW'(2);
    localparam logic [PW-1:0] PH_PARITY = PW'(DATA_BITS + 2);
    localparam logic [PW-1:0] PH_LAST   = PW'(DATA_BITS + 2 + STOP_BITS);
    localparam logic [PW-1:0] PH_BYTE   = PW'(BYTE_W);

    logic [PW-1:0]      send_phase_reg, send_phase_next;
    logic [BYTE_W-1:0]  send_shift_reg, send_shift_next;
    logic [TIMER_W-1:0] send_timer_reg, send_timer_next;
    logic               send_parity_reg, send_parity_next;
    logic [PW-1:0]      recv_phase_reg, recv_phase_next;
    logic [BYTE_W-1:0]  recv_shift_reg, recv_shift_next;
    logic [TIMER_W-1:0] recv_timer_reg, recv_timer_next;
    logic               recv_parity_reg, recv_parity_next;
    logic               line_previous_reg;
    logic [COUNT_W-1:0] fault_total_reg, fault_total_next;
    logic [BYTE_W-1:0]  recv_hold_reg, recv_hold_next;

    logic               byte_parity;
    logic [TIMER_W-1:0] send_tick;
    logic [TIMER_W-1:0] recv_tick;
    logic [TIMER_W-1:0] recv_target;
    logic [PW-1:0]      tx_n;
    logic [PW-1:0]      rx_n;
    logic               pull;
    logic               ready;
    logic               bad;

    // Even parity over the data bits that carry byte content
    always_comb begin
        byte_parity = 1'b0;
        for (int i = 0; i < BYTE_W; i++) begin
            if (i < DATA_BITS) begin
                byte_parity = byte_parity ^ item.send_byte[i];
            end
        end
    end

    // Transmitter: load on request, advance one bit per period
    always_comb begin
        send_phase_next  = send_phase_reg;
        send_shift_next  = send_shift_reg;
        send_timer_next  = send_timer_reg;
        send_parity_next = send_parity_reg;
        send_tick        = send_timer_reg + TIMER_W'(1);
        if (send_phase_reg == PH_IDLE) begin
            if (item.send_request) begin
                send_phase_next  = PH_START;
                send_timer_next  = '0;
                send_shift_next  = item.send_byte;
                send_parity_next = byte_parity;
            end
        end else if (send_tick >= tx_period) begin
            send_timer_next = '0;
            send_phase_next = (send_phase_reg == PH_LAST) ? PH_IDLE
                                                          : send_phase_reg + PW'(1);
        end else begin
            send_timer_next = send_tick;
        end
    end

    // Line drive: start bit low, data and parity inverted, stop bits released
    assign tx_n = send_phase_next - PH_DATA0;
    always_comb begin
        pull = 1'b0;
        if (send_phase_next == PH_START) begin
            pull = 1'b1;
        end else if (send_phase_next >= PH_DATA0 && send_phase_next < PH_PARITY) begin
            pull = (tx_n < PH_BYTE) ? ~send_shift_next[tx_n[2:0]] : 1'b1;
        end else if (send_phase_next == PH_PARITY) begin
            pull = ~send_parity_next;
        end
    end

    // Receiver: hunt for a falling edge, then sample mid-bit
    assign recv_target = (recv_phase_reg == PH_START) ? (rx_period >> 1) : rx_period;
    assign recv_tick   = recv_timer_reg + TIMER_W'(1);
    assign rx_n        = recv_phase_reg - PH_DATA0;
    always_comb begin
        recv_phase_next  = recv_phase_reg;
        recv_shift_next  = recv_shift_reg;
        recv_timer_next  = recv_timer_reg;
        recv_parity_next = recv_parity_reg;
        recv_hold_next   = recv_hold_reg;
        fault_total_next = fault_total_reg;
        ready            = 1'b0;
        bad              = 1'b0;
        if (send_phase_next != PH_IDLE) begin
            recv_phase_next = PH_IDLE;
            recv_timer_next = '0;
        end else if (recv_phase_reg == PH_IDLE) begin
            if (line_previous_reg && !item.line_sample) begin
                recv_shift_next  = '0;
                recv_parity_next = 1'b0;
                recv_timer_next  = '0;
                recv_phase_next  = ((rx_period >> 1) == '0) ? PH_DATA0 : PH_START;
            end
        end else if (recv_tick >= recv_target) begin
            recv_timer_next = '0;
            if (recv_phase_reg == PH_START) begin
                recv_phase_next = PH_DATA0;
            end else if (recv_phase_reg < PH_PARITY) begin
                if (rx_n < PH_BYTE) begin
                    recv_shift_next[rx_n[2:0]] = recv_shift_reg[rx_n[2:0]] | item.line_sample;
                end
                recv_parity_next = recv_parity_reg ^ item.line_sample;
                recv_phase_next  = recv_phase_reg + PW'(1);
            end else begin
                ready          = 1'b1;
                bad            = (item.line_sample != recv_parity_reg);
                recv_hold_next = recv_shift_reg;
                if (bad && fault_total_reg != {COUNT_W{1'b1}}) begin
                    fault_total_next = fault_total_reg + COUNT_W'(1);
                end
                recv_phase_next = PH_IDLE;
            end
        end else begin
            recv_timer_next = recv_tick;
        end
    end

    // Commit state on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_phase_reg    <= PH_IDLE;
            send_shift_reg    <= '0;
            send_timer_reg    <= '0;
            send_parity_reg   <= 1'b0;
            recv_phase_reg    <= PH_IDLE;
            recv_shift_reg    <= '0;
            recv_timer_reg    <= '0;
            recv_parity_reg   <= 1'b0;
            line_previous_reg <= 1'b1;
            fault_total_reg   <= '0;
            recv_hold_reg     <= '0;
        end else if (step) begin
            send_phase_reg    <= send_phase_next;
            send_shift_reg    <= send_shift_next;
            send_timer_reg    <= send_timer_next;
            send_parity_reg   <= send_parity_next;
            recv_phase_reg    <= recv_phase_next;
            recv_shift_reg    <= recv_shift_next;
            recv_timer_reg    <= recv_timer_next;
            recv_parity_reg   <= recv_parity_next;
            line_previous_reg <= item.line_sample;
            fault_total_reg   <= fault_total_next;
            recv_hold_reg     <= recv_hold_next;
        end
    end

    // Result of this tick
    always_comb begin
        result.line_pull_low      = pull;
        result.sender_busy        = (send_phase_next != PH_IDLE);
        result.byte_ready         = ready;
        result.received_byte      = recv_hold_next;
        result.parity_bad         = bad;
        result.parity_fault_count = fault_total_next;
    end

`ifndef ASSERT_OFF
    // Receiver stays parked while a frame goes out
    a_rx_parked: assert property (@(posedge aclk) disable iff (!aresetn)
        send_phase_reg != PH_IDLE |-> recv_phase_reg == PH_IDLE)
        else $error("receiver active during transmit");

    // Fault counter never goes backward
    a_count_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> fault_total_reg >= $past(fault_total_reg))
        else $error("parity fault count decreased");

    // A completed frame only comes out of the parity sample
    a_ready_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        result.byte_ready |-> recv_phase_reg == PH_PARITY && send_phase_next == PH_IDLE)
        else $error("frame completed outside parity sample");

    // Phases stay within the frame
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        send_phase_reg <= PH_LAST && recv_phase_reg <= PH_PARITY)
        else $error("phase out of range");
`endif

endmodule

`default_nettype wire

FILE: sv/single_wire_uart_8e2.sv
// ----------------------------------------------------------------------------
// single_wire_uart_8e2: half-duplex open-drain UART, 8 data bits, even parity
// Stream wrapper with configuration registers around the UART tick logic.
// ----------------------------------------------------------------------------
// Each input item is one tick of the serial line: a send request with its
// byte and the sampled line level. Each item yields exactly one result item
// with the line drive, busy flag and receive status for that tick. The block
// takes one item per clock while results are taken; each item passes through
// the input register and then the result register around the single tick
// update. Both sides may stall freely. Bit times are written through the
// configuration port (index 0 transmit, index 1 receive, ticks per bit, 0 acts
// as 1) and must only change while no item is in flight.
`default_nettype none

module single_wire_uart_8e2 #(
    parameter int DATA_BITS = 8,
    parameter int STOP_BITS = 2
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // Input items
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // send_request[0], send_byte[8:1], line_sample[9], zero[15:10]
    input  wire  [swu_pkg::S_TDATA_W-1:0]        s_tdata,
    // Result items
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // line_pull_low[0], sender_busy[1], byte_ready[2], received_byte[10:3],
    // parity_bad[11], parity_fault_count[19:12], zero[23:20]
    output logic [swu_pkg::M_TDATA_W-1:0]        m_tdata,
    // Configuration writes
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [swu_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire  [swu_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import swu_pkg::*;

    logic [CFG_DATA_W-1:0] tx_bit_cycles_reg;
    logic [CFG_DATA_W-1:0] rx_bit_cycles_reg;
    logic [TIMER_W-1:0]    tx_period;
    logic [TIMER_W-1:0]    rx_period;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t core_result;
    logic    advance;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_bit_cycles_reg <= BIT_CYCLES_RESET;
            rx_bit_cycles_reg <= BIT_CYCLES_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_TX_BIT_CYCLES) begin
                tx_bit_cycles_reg <= cfg_data;
            end else if (cfg_index == CFG_RX_BIT_CYCLES) begin
                rx_bit_cycles_reg <= cfg_data;
            end
        end
    end

    // Treat a zero period as one tick
    assign tx_period = (tx_bit_cycles_reg == '0) ? TIMER_W'(1) : tx_bit_cycles_reg;
    assign rx_period = (rx_bit_cycles_reg == '0) ? TIMER_W'(1) : rx_bit_cycles_reg;

    // Advance when an item is held and the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= item_t'(s_tdata[S_FIELDS_W-1:0]);
        end
    end

    swu_core #(
        .DATA_BITS (DATA_BITS),
        .STOP_BITS (STOP_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (in_item_reg),
        .tx_period (tx_period),
        .rx_period (rx_period),
        .result    (core_result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, out_result_reg};

`ifndef ASSERT_OFF
    // A held result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !advance)
        else $error("result overwritten while stalled");

    // An item waiting in the input register blocks new input
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |-> !s_tready)
        else $error("input accepted over a held item");

    // Every advance produces a valid result next cycle
    a_adv_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("advanced item produced no result");
`endif

endmodule

`default_nettype wire
